[rtl/hcbd_pkg.sv]
// shared types, constants and helpers for the chunked body decoder
package hcbd_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 24;
  localparam int unsigned CFG_WIDTH       = 24;
  localparam logic [CFG_WIDTH-1:0] MAX_CHUNK_RESET = 24'h10_0000;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  typedef enum logic [2:0] {
    PH_SIZE_FIRST,
    PH_SIZE_DIGITS,
    PH_SIZE_EXT,
    PH_SIZE_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_ENDED
  } phase_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic [1:0] kind;
  } res_t;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    case (c) inside
      [8'h30:8'h39]: v = 5'(c - 8'h30);
      [8'h41:8'h46]: v = 5'(c - 8'h41 + 8'd10);
      [8'h61:8'h66]: v = 5'(c - 8'h61 + 8'd10);
      default:       v = 5'h10;
    endcase
    return v;
  endfunction

endpackage

[rtl/hcbd_parser.sv]
// byte-wise chunk framing state machine with size and count registers
module hcbd_parser
  import hcbd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 new_body,
  input  logic [CFG_WIDTH-1:0] max_chunk,
  output res_t                 res,
  output phase_t               phase
);

  localparam int unsigned CMPW = (COUNT_WIDTH + 4 > CFG_WIDTH) ? COUNT_WIDTH + 4 : CFG_WIDTH;

  phase_t                 phase_r, phase_nxt, ph;
  logic [COUNT_WIDTH-1:0] accum_r, accum_nxt, accum_eff, acc_base;
  logic [COUNT_WIDTH-1:0] left_r, left_nxt, left_dec;
  logic [COUNT_WIDTH+3:0] v;
  logic [4:0]             d;
  logic                   is_hex, add_ok;

  assign phase = phase_r;

  // a new body restarts parsing on this very byte
  assign ph        = new_body ? PH_SIZE_FIRST : phase_r;
  assign accum_eff = new_body ? '0 : accum_r;
  assign acc_base  = (ph == PH_SIZE_FIRST) ? '0 : accum_eff;
  assign d         = hex_value(data_byte);
  assign is_hex    = ~d[4];
  assign v         = {acc_base, d[3:0]};
  assign add_ok    = (v[COUNT_WIDTH+3:COUNT_WIDTH] == 4'd0) &&
                     (CMPW'(v) <= CMPW'(max_chunk));
  assign left_dec  = left_r - COUNT_WIDTH'(1);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    left_nxt  = left_r;
    if (accept) begin
      phase_nxt = ph;
      accum_nxt = accum_eff;
      if (new_body) begin
        left_nxt = '0;
      end
      case (ph)
        PH_SIZE_FIRST: begin
          if (is_hex && add_ok) begin
            accum_nxt = v[COUNT_WIDTH-1:0];
            phase_nxt = PH_SIZE_DIGITS;
          end else begin
            accum_nxt = '0;
            phase_nxt = PH_ENDED;
          end
        end
        PH_SIZE_DIGITS: begin
          if (data_byte == CH_CR) begin
            phase_nxt = PH_SIZE_LF;
          end else if (!is_hex) begin
            phase_nxt = PH_SIZE_EXT;
          end else if (add_ok) begin
            accum_nxt = v[COUNT_WIDTH-1:0];
          end else begin
            phase_nxt = PH_ENDED;
          end
        end
        PH_SIZE_EXT: begin
          if (data_byte == CH_CR) phase_nxt = PH_SIZE_LF;
        end
        PH_SIZE_LF: begin
          if (data_byte != CH_LF || accum_eff == '0) begin
            phase_nxt = PH_ENDED;
          end else begin
            left_nxt  = accum_eff;
            accum_nxt = '0;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          left_nxt = left_dec;
          if (left_dec == '0) phase_nxt = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          phase_nxt = (data_byte == CH_CR) ? PH_DATA_LF : PH_ENDED;
        end
        PH_DATA_LF: begin
          phase_nxt = (data_byte == CH_LF) ? PH_SIZE_FIRST : PH_ENDED;
        end
        default: phase_nxt = PH_ENDED;
      endcase
    end
  end

  // result for the accepted byte
  always_comb begin
    res = '{vld: 1'b0, data: 8'd0, kind: KIND_PAYLOAD};
    if (accept) begin
      case (ph)
        PH_SIZE_FIRST: begin
          if (!(is_hex && add_ok)) res = '{vld: 1'b1, data: 8'd0, kind: KIND_BAD};
        end
        PH_SIZE_DIGITS: begin
          if (data_byte != CH_CR && is_hex && !add_ok) begin
            res = '{vld: 1'b1, data: 8'd0, kind: KIND_BAD};
          end
        end
        PH_SIZE_LF: begin
          if (data_byte != CH_LF) begin
            res = '{vld: 1'b1, data: 8'd0, kind: KIND_BAD};
          end else if (accum_eff == '0) begin
            res = '{vld: 1'b1, data: 8'd0, kind: KIND_DONE};
          end
        end
        PH_DATA: res = '{vld: 1'b1, data: data_byte, kind: KIND_PAYLOAD};
        PH_DATA_CR: begin
          if (data_byte != CH_CR) res = '{vld: 1'b1, data: 8'd0, kind: KIND_BAD};
        end
        PH_DATA_LF: begin
          if (data_byte != CH_LF) res = '{vld: 1'b1, data: 8'd0, kind: KIND_BAD};
        end
        default: res = '{vld: 1'b0, data: 8'd0, kind: KIND_PAYLOAD};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE_FIRST;
      accum_r <= '0;
      left_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

[rtl/http_chunked_body_decoder.sv]
// chunked http body decoder: one byte in, zero or one result out
// a result is registered in out_r before it shows on out_*, via the skid entry under an output stall
// throughput: one byte per cycle with the skid empty; the parser state register is the only loop
// in_tready falls only while the skid entry holds a result that arrived under an output stall
// reset (rst_n low, synchronous) clears the parser, empties the output and sets the limit to 1048576
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_byte
  input  logic                 in_tuser,   // [0] new_body
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] out_byte
  output logic [1:0]           out_tuser,  // [1:0] kind
  input  logic                 cfg_we,
  input  logic [CFG_WIDTH-1:0] cfg_wdata   // max_chunk_size
);

  logic [CFG_WIDTH-1:0] max_chunk_r;
  res_t                 res, out_r, out_nxt, skid_r, skid_nxt;
  phase_t               phase;
  logic                 in_xfer;

  assign in_tready = ~skid_r.vld;
  assign in_xfer   = in_tvalid & in_tready;

  hcbd_parser #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_xfer),
    .data_byte (in_tdata),
    .new_body  (in_tuser),
    .max_chunk (max_chunk_r),
    .res       (res),
    .phase     (phase)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chunk_r <= MAX_CHUNK_RESET;
    end else if (cfg_we) begin
      max_chunk_r <= cfg_wdata;
    end
  end

  // skid only fills when the output register is stalled
  always_comb begin
    out_nxt  = out_r;
    skid_nxt = skid_r;
    if (!out_r.vld || out_tready) begin
      if (skid_r.vld) begin
        out_nxt      = skid_r;
        skid_nxt.vld = 1'b0;
      end else begin
        out_nxt = res;
      end
    end else if (res.vld) begin
      skid_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld  <= 1'b0;
      skid_r.vld <= 1'b0;
    end else begin
      out_r.vld  <= out_nxt.vld;
      skid_r.vld <= skid_nxt.vld;
    end
    out_r.data  <= out_nxt.data;
    out_r.kind  <= out_nxt.kind;
    skid_r.data <= skid_nxt.data;
    skid_r.kind <= skid_nxt.kind;
  end

  assign out_tvalid = out_r.vld;
  assign out_tdata  = out_r.data;
  assign out_tuser  = out_r.kind;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_r.vld |-> out_r.vld)
    else $error("skid entry held while output register empty");

  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res.vld && res.kind != KIND_PAYLOAD) |=> phase == PH_ENDED)
    else $error("parser not stopped after completion or error");

  a_no_result_when_ended: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_tuser && phase == PH_ENDED) |-> !res.vld)
    else $error("result produced after body ended");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != KIND_UNUSED)
    else $error("illegal result kind");

endmodule

[tb/tb_http_chunked_body_decoder.sv]
// self-checking testbench for the chunked http body decoder
module tb_http_chunked_body_decoder
  import hcbd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_TARGET = 850;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;

  typedef struct {
    logic [7:0] b;
    logic [1:0] kind;
  } decoded_t;

  typedef struct {
    logic [7:0] b;
    logic       nb;
  } raw_item_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;  // [7:0] data_byte
  logic                 in_tuser   = 1'b0;  // [0] new_body
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;  // [7:0] out_byte
  logic [1:0]           out_tuser;  // [1:0] kind
  logic                 cfg_we     = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_wdata  = '0;  // max_chunk_size

  // decoder state mirrored by the predictor
  phase_t               parse_ph    = PH_SIZE_FIRST;
  logic [23:0]          size_acc    = '0;
  logic [23:0]          data_left   = '0;
  logic [CFG_WIDTH-1:0] chunk_limit = MAX_CHUNK_RESET;

  decoded_t  decoded_due[$];
  raw_item_t burst_q[$];
  decoded_t  want;
  logic      next_nb     = 1'b0;
  bit        send_idle   = 1'b1;
  bit        ready_idle  = 1'b1;
  int        holds_asked = 0;
  int        holds_done  = 0;
  int        items_sent  = 0;
  int        mismatches  = 0;
  int        n_payload   = 0;
  int        n_done      = 0;
  int        n_bad       = 0;
  int        idle_cycles = 0;

  http_chunked_body_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    return 5'h10;
  endfunction

  function automatic bit take_digit(input logic [3:0] d);
    logic [27:0] v;
    v = {size_acc, d};
    if (v > {4'h0, chunk_limit}) return 1'b0;
    size_acc = v[23:0];
    return 1'b1;
  endfunction

  function automatic void decode_byte(input logic [7:0] c, input logic nb);
    logic [4:0] d;
    logic       bad;
    logic       has;
    decoded_t   r;
    bad    = 1'b0;
    has    = 1'b0;
    r.b    = 8'h00;
    r.kind = KIND_PAYLOAD;
    if (nb) begin
      parse_ph  = PH_SIZE_FIRST;
      size_acc  = '0;
      data_left = '0;
    end
    d = nibble_of(c);
    case (parse_ph)
      PH_SIZE_FIRST: begin
        if (d[4]) bad = 1'b1;
        else begin
          size_acc = '0;
          if (!take_digit(d[3:0])) bad = 1'b1;
          else parse_ph = PH_SIZE_DIGITS;
        end
      end
      PH_SIZE_DIGITS: begin
        if (c == CH_CR) parse_ph = PH_SIZE_LF;
        else if (d[4]) parse_ph = PH_SIZE_EXT;
        else if (!take_digit(d[3:0])) bad = 1'b1;
      end
      PH_SIZE_EXT: begin
        if (c == CH_CR) parse_ph = PH_SIZE_LF;
      end
      PH_SIZE_LF: begin
        if (c != CH_LF) bad = 1'b1;
        else if (size_acc == 0) begin
          parse_ph = PH_ENDED;
          has      = 1'b1;
          r.kind   = KIND_DONE;
        end else begin
          data_left = size_acc;
          size_acc  = '0;
          parse_ph  = PH_DATA;
        end
      end
      PH_DATA: begin
        data_left = data_left - 1'b1;
        if (data_left == 0) parse_ph = PH_DATA_CR;
        has = 1'b1;
        r.b = c;
      end
      PH_DATA_CR: begin
        if (c != CH_CR) bad = 1'b1;
        else parse_ph = PH_DATA_LF;
      end
      PH_DATA_LF: begin
        if (c != CH_LF) bad = 1'b1;
        else parse_ph = PH_SIZE_FIRST;
      end
      default: ;
    endcase
    if (bad) begin
      parse_ph = PH_ENDED;
      has      = 1'b1;
      r.kind   = KIND_BAD;
    end
    if (has) decoded_due.push_back(r);
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int pick_gap();
    int r;
    if (!send_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
  endfunction

  task automatic add_byte(input logic [7:0] b);
    burst_q.push_back('{b: b, nb: next_nb});
    next_nb = 1'b0;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endtask

  // hex size with random case, optional leading zeros and an optional extension
  task automatic add_size_line(input int unsigned sz);
    int         nd;
    logic [7:0] c;
    nd = 1;
    while (nd < 6 && (sz >> (4 * nd)) != 0) nd++;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) add_byte("0");
    for (int i = nd - 1; i >= 0; i--) add_byte(hex_char(4'(sz >> (4 * i))));
    if ($urandom_range(0, 4) == 0) begin
      add_byte(";");
      repeat ($urandom_range(0, 4)) begin
        c = 8'($urandom);
        if (c == CH_CR) c = "=";
        add_byte(c);
      end
    end
    add_crlf();
  endtask

  task automatic add_clean_body();
    int unsigned cap;
    int unsigned sz;
    next_nb = 1'b1;
    cap = (chunk_limit < 12) ? chunk_limit : 12;
    repeat ($urandom_range(0, 3)) begin
      if (cap == 0) break;
      sz = $urandom_range(1, cap);
      if ($urandom_range(0, 9) == 0 && chunk_limit >= 40) sz = $urandom_range(13, 40);
      add_size_line(sz);
      repeat (sz) add_byte(8'($urandom));
      add_crlf();
    end
    add_size_line(0);
    if ($urandom_range(0, 2) == 0) begin
      add_text("x-t: 1");
      add_crlf();
    end
    add_crlf();
  endtask

  // size line beyond the limit, then a few bytes that must be ignored
  task automatic add_oversize_body();
    next_nb = 1'b1;
    if (chunk_limit < 24'hFFFFFF && $urandom_range(0, 3) != 0)
      add_size_line($urandom_range(int'(chunk_limit) + 1, 24'hFFFFFF));
    else
      add_text("1000000");
    repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
  endtask

  task automatic send_item(input logic [7:0] b, input logic nb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= nb;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(b, nb);
    items_sent++;
  endtask

  task automatic send_burst();
    raw_item_t it;
    while (burst_q.size() != 0) begin
      it = burst_q.pop_front();
      send_item(it.b, it.nb);
    end
  endtask

  // register writes only once every result is out and the pipe has drained
  task automatic write_limit(input logic [CFG_WIDTH-1:0] v);
    in_tvalid <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    chunk_limit = v;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    // extension text, zero data byte, completion, trailer ignored
    next_nb = 1'b1;
    add_text("1;x");
    add_crlf();
    add_byte(8'h00);
    add_crlf();
    add_text("0");
    add_crlf();
    add_text("T");
    // non-hex size, then a byte after the error
    next_nb = 1'b1;
    add_text("g7");
    // empty size line
    next_nb = 1'b1;
    add_byte(CH_CR);
    // bare cr in size line
    next_nb = 1'b1;
    add_text("1");
    add_byte(CH_CR);
    add_text("x");
    // cr inside data, all-ones byte, missing crlf after data
    next_nb = 1'b1;
    add_text("2");
    add_crlf();
    add_byte(CH_CR);
    add_byte(8'hFF);
    add_text("x");
    send_burst();
  endtask

  task automatic test_limit_register();
    // zero limit: only size zero completes
    write_limit('0);
    next_nb = 1'b1;
    add_text("0");
    add_crlf();
    next_nb = 1'b1;
    add_text("1");
    send_burst();

    write_limit(24'd1);
    next_nb = 1'b1;
    add_text("1");
    add_crlf();
    add_text("Z");
    add_crlf();
    add_text("0");
    add_crlf();
    next_nb = 1'b1;
    add_text("2");
    send_burst();

    // top limit: largest size is accepted, a seventh digit overflows the counter
    write_limit(24'hFFFFFF);
    next_nb = 1'b1;
    add_text("fFfFfF");
    add_crlf();
    next_nb = 1'b1;
    add_text("1000000");
    repeat (5) begin
      if ($urandom_range(0, 2) == 0) add_oversize_body();
      else add_clean_body();
    end
    send_burst();

    write_limit(CFG_WIDTH'($urandom_range(2, 20)));
    repeat (10) begin
      if ($urandom_range(0, 2) == 0) add_oversize_body();
      else add_clean_body();
    end
    send_burst();

    write_limit(MAX_CHUNK_RESET);
  endtask

  task automatic test_output_holdoff();
    send_idle = 1'b0;
    holds_asked++;
    next_nb = 1'b1;
    add_size_line(48);
    repeat (48) add_byte(8'($urandom));
    add_crlf();
    add_size_line(0);
    send_burst();
    send_idle = 1'b1;
  endtask

  task automatic test_random_bodies();
    int r;
    int pos;
    while (items_sent < ITEMS_TARGET) begin
      if ($urandom_range(0, 9) == 0) send_idle = !send_idle;
      if ($urandom_range(0, 9) == 0) ready_idle = !ready_idle;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        add_clean_body();
        // damage a quarter of the bodies: overwrite, cut short or insert a byte
        if ($urandom_range(0, 3) == 0) begin
          pos = $urandom_range(1, burst_q.size() - 1);
          case ($urandom_range(0, 2))
            0: burst_q[pos].b = 8'($urandom);
            1: while (burst_q.size() > pos) void'(burst_q.pop_back());
            default: burst_q.insert(pos, '{b: 8'($urandom), nb: 1'b0});
          endcase
        end
      end else if (r < 90) begin
        add_oversize_body();
      end else begin
        // loose bytes, sometimes flagged as a fresh body
        repeat ($urandom_range(1, 4)) begin
          next_nb = ($urandom_range(0, 3) == 0);
          add_byte(8'($urandom));
        end
      end
      send_burst();
    end
    send_idle  = 1'b1;
    ready_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------- processes

  initial begin : ready_driver
    int r;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else if (!ready_idle) begin
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) out_tready <= 1'b1;
        else if (r < 95) out_tready <= 1'b0;
        else begin
          out_tready <= 1'b0;
          repeat ($urandom_range(5, 30)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      case (out_tuser)
        KIND_PAYLOAD: n_payload++;
        KIND_DONE:    n_done++;
        default:      n_bad++;
      endcase
      if (decoded_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte %02h kind %0d", out_tdata, out_tuser);
      end else begin
        want = decoded_due.pop_front();
        if (out_tdata !== want.b || out_tuser !== want.kind) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected byte %02h kind %0d, got byte %02h kind %0d",
                     want.b, want.kind, out_tdata, out_tuser);
        end
      end
    end
  end

  // no transfer of any kind for too long means the block hung
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_limit_register();
    test_output_holdoff();
    test_random_bodies();

    in_tvalid <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (decoded_due.size() != 0) mismatches++;

    $display("%0d input transfers checked: %0d payload bytes, %0d completions, %0d malformed",
             items_sent, n_payload, n_done, n_bad);
    $display("limit swept over 0, 1, 0xffffff and a random value, with one long output hold-off");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
